[rtl/core/gdil_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the recursive Gaussian-derivative line engine.
// No dependencies; imported by gaussian_derivative_iir_line.
package gdil_pkg;

    localparam int MAX_LINE    = 4096;
    localparam int ADDR_W      = $clog2(MAX_LINE);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 8;
    localparam int VAL_W       = 40;
    localparam int VAL_FRAC    = 16;
    localparam int COEF_W      = 32;
    localparam int COEF_FRAC_BITS = 26;
    localparam int HALF_W      = VAL_W / 2;
    localparam int MUL_W       = HALF_W + 1 + COEF_W;
    localparam int FULL_W      = MUL_W + HALF_W;
    localparam int TERM_W      = FULL_W - COEF_FRAC_BITS;
    localparam int ACC_W       = TERM_W + 2;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int RAD_W       = 50;
    localparam int SQRT_STEPS  = RAD_W / 2;
    localparam int REM_W       = SQRT_STEPS + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int PC_W        = 17;
    localparam logic [PC_W-1:0] PC_RESET = 17'd8192;
    localparam logic [4:0] STEP_ISSUE_FIRST = 5'd1;
    localparam logic [4:0] STEP_ISSUE_LAST  = 5'd16;
    localparam logic [4:0] STEP_FINISH      = 5'd19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FWD_NUM_01   = 3'd0,
        REG_FWD_NUM_23   = 3'd1,
        REG_DEN_12       = 3'd2,
        REG_DEN_34       = 3'd3,
        REG_BWD_NUM_12   = 3'd4,
        REG_BWD_NUM_34   = 3'd5,
        REG_EDGE_GAINS   = 3'd6,
        REG_PASS_CONTROL = 3'd7
    } cfg_reg_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CINIT = 9'b000000010,
        ST_CRUN  = 9'b000000100,
        ST_AINIT = 9'b000001000,
        ST_ARUN  = 9'b000010000,
        ST_VSQ   = 9'b000100000,
        ST_MG1   = 9'b001000000,
        ST_MG2   = 9'b010000000,
        ST_ROOT  = 9'b100000000
    } state_t;

endpackage

[rtl/core/gaussian_derivative_iir_line.sv]
`timescale 1ns / 1ps
// Line engine: sample memory and line memory (causal results, then output bytes),
// shared MAC and root unit. Depends on gdil_pkg.
// Load: one sample per cycle while idle. Last sample starts a walk over L samples
// (causal init and pass, anticausal init and pass) on one 21x32 multiplier doing
// 16 partial products per tap set. Drain: result registered after VSQ in clamp mode,
// after MG1, MG2 and bit-serial 25-step root in gradient. Results cannot be stalled.
// Reset sets control state and config; datapath regs and memories start undefined.
module gaussian_derivative_iir_line (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               operation,
    input  logic [gdil_pkg::SAMPLE_W-1:0]      sample,
    input  logic [gdil_pkg::SAMPLE_W-1:0]      other_pass,
    input  logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gdil_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                        cfg_data,
    output logic                               result_strobe,
    output logic [gdil_pkg::SAMPLE_W-1:0]      result_value,
    output logic                               result_last
);
    import gdil_pkg::*;

    state_t state_reg, state_next;

    logic [63:0] fwd_num_01_reg, fwd_num_23_reg, den_12_reg, den_34_reg;
    logic [63:0] bwd_num_12_reg, bwd_num_34_reg, edge_gains_reg;
    logic [PC_W-1:0] pass_control_reg;

    logic [SAMPLE_W-1:0] samp_mem [MAX_LINE];
    logic [VAL_W-1:0]    line_mem [MAX_LINE];
    logic [SAMPLE_W-1:0] samp_q_reg;
    logic [VAL_W-1:0]    line_q_reg;
    logic [SAMPLE_W-1:0] out_q;
    logic [ADDR_W-1:0]   line_addr;

    logic [LEN_W-1:0]  line_length_reg, drain_pos_reg;
    logic              line_ready_reg;
    logic [ADDR_W-1:0] n_reg;
    logic [4:0]        step_reg;

    logic [SAMPLE_W-1:0]      xh_reg [4];
    logic signed [VAL_W-1:0]  yh_reg [4];

    logic signed [MUL_W-1:0]  mul_reg, lo_reg;
    logic                     mul_v_reg, mul_h_reg, mul_neg_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic                     term_v_reg, term_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [SAMPLE_W-1:0] h_reg;
    logic [RAD_W-2:0]    prod_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SQRT_STEPS-1:0] root_reg;
    logic [4:0]          iter_reg;

    logic                result_strobe_reg, result_last_reg;
    logic [SAMPLE_W-1:0] result_value_reg;

    logic accept, load_acc, drain_acc, pending;
    logic [LEN_W-1:0]  len_eff, pos_inc;
    logic [ADDR_W-1:0] last_idx;
    logic in_walk, is_init, causal, issue, finish;
    logic [3:0] issue_idx;
    logic [2:0] t_sel;
    logic [SAMPLE_W-1:0]      x_byte;
    logic signed [VAL_W-1:0]  operand;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [HALF_W:0]   op_half;
    logic signed [COEF_W-1:0] n_c [4];
    logic signed [COEF_W-1:0] m_c [4];
    logic signed [COEF_W-1:0] d_c [4];
    logic signed [FULL_W-1:0] full_sum;
    logic [VAL_W-1:0]   sat_val;
    logic signed [VAL_W:0] line_sum;
    logic [SAMPLE_W-1:0] clamp_byte;
    logic [16:0] sq_sum;
    logic [REM_W+1:0] rem_shift, trial;
    logic emit;
    logic [SAMPLE_W-1:0] emit_value, grad_byte;
    logic mode;
    logic [GAIN_W-1:0] gain;

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign result_strobe = result_strobe_reg;
    assign result_value  = result_value_reg;
    assign result_last   = result_last_reg;

    assign mode = pass_control_reg[0];
    assign gain = pass_control_reg[GAIN_W:1];

    assign accept    = start && !busy;
    assign load_acc  = accept && !operation;
    assign drain_acc = accept && operation;
    assign len_eff   = line_ready_reg ? '0 : line_length_reg;
    assign pending   = line_ready_reg && (drain_pos_reg < line_length_reg);
    assign pos_inc   = LEN_W'(drain_pos_reg + 1'b1);
    assign last_idx  = ADDR_W'(line_length_reg - 1'b1);

    assign in_walk   = (state_reg == ST_CINIT) || (state_reg == ST_CRUN)
                    || (state_reg == ST_AINIT) || (state_reg == ST_ARUN);
    assign is_init   = (state_reg == ST_CINIT) || (state_reg == ST_AINIT);
    assign causal    = (state_reg == ST_CINIT) || (state_reg == ST_CRUN);
    assign issue     = in_walk && (step_reg >= STEP_ISSUE_FIRST) && (step_reg <= STEP_ISSUE_LAST);
    assign finish    = in_walk && (step_reg == STEP_FINISH);
    assign issue_idx = 4'(step_reg - STEP_ISSUE_FIRST);
    assign t_sel     = issue_idx[3:1];

    assign line_addr = in_walk ? n_reg : drain_pos_reg[ADDR_W-1:0];
    assign out_q     = line_q_reg[SAMPLE_W-1:0];

    assign n_c[0] = fwd_num_01_reg[63:32];
    assign n_c[1] = fwd_num_01_reg[31:0];
    assign n_c[2] = fwd_num_23_reg[63:32];
    assign n_c[3] = fwd_num_23_reg[31:0];
    assign m_c[0] = bwd_num_12_reg[63:32];
    assign m_c[1] = bwd_num_12_reg[31:0];
    assign m_c[2] = bwd_num_34_reg[63:32];
    assign m_c[3] = bwd_num_34_reg[31:0];
    assign d_c[0] = den_12_reg[63:32];
    assign d_c[1] = den_12_reg[31:0];
    assign d_c[2] = den_34_reg[63:32];
    assign d_c[3] = den_34_reg[31:0];

    always_comb
    begin
        x_byte = samp_q_reg;
        if (state_reg == ST_CRUN && t_sel[1:0] != 2'd0)
        begin
            x_byte = xh_reg[2'(t_sel[1:0] - 2'd1)];
        end
        else if (state_reg == ST_ARUN)
        begin
            x_byte = xh_reg[t_sel[1:0]];
        end

        if (t_sel[2] && !is_init)
        begin
            operand = yh_reg[t_sel[1:0]];
        end
        else
        begin
            operand = $signed({{(VAL_W-VAL_FRAC-SAMPLE_W){1'b0}}, x_byte, {VAL_FRAC{1'b0}}});
        end

        if (is_init)
        begin
            if (t_sel == 3'd0)
            begin
                coef_sel = causal ? $signed(edge_gains_reg[63:32]) : $signed(edge_gains_reg[31:0]);
            end
            else
            begin
                coef_sel = '0;
            end
        end
        else if (t_sel[2])
        begin
            coef_sel = d_c[t_sel[1:0]];
        end
        else
        begin
            coef_sel = causal ? n_c[t_sel[1:0]] : m_c[t_sel[1:0]];
        end

        if (issue_idx[0])
        begin
            op_half = $signed({operand[VAL_W-1], operand[VAL_W-1:HALF_W]});
        end
        else
        begin
            op_half = $signed({1'b0, operand[HALF_W-1:0]});
        end
    end

    assign full_sum = $signed({mul_reg, {HALF_W{1'b0}}})
                    + $signed({{HALF_W{lo_reg[MUL_W-1]}}, lo_reg});

    always_comb
    begin
        if (acc_reg[ACC_W-1:VAL_W-1] == '0 || acc_reg[ACC_W-1:VAL_W-1] == '1)
        begin
            sat_val = acc_reg[VAL_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
        end

        line_sum = $signed({line_q_reg[VAL_W-1], line_q_reg}) + $signed({sat_val[VAL_W-1], sat_val});
        if (line_sum[VAL_W])
        begin
            clamp_byte = '0;
        end
        else if (|line_sum[VAL_W-1:VAL_FRAC+SAMPLE_W])
        begin
            clamp_byte = '1;
        end
        else
        begin
            clamp_byte = line_sum[VAL_FRAC+SAMPLE_W-1:VAL_FRAC];
        end
    end

    assign sq_sum = 17'(out_q) * 17'(out_q) + 17'(h_reg) * 17'(h_reg);
    assign rem_shift = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign grad_byte = (|root_reg[SQRT_STEPS-1:GAIN_FRAC+SAMPLE_W]) ? '1
                     : root_reg[GAIN_FRAC+SAMPLE_W-1:GAIN_FRAC];

    always_comb
    begin
        emit       = 1'b0;
        emit_value = out_q;
        if (state_reg == ST_VSQ && !mode)
        begin
            emit = 1'b1;
        end
        else if (state_reg == ST_ROOT && iter_reg == 5'(SQRT_STEPS))
        begin
            emit       = 1'b1;
            emit_value = grad_byte;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_acc && last)
                begin
                    state_next = ST_CINIT;
                end
                else if (drain_acc && pending)
                begin
                    state_next = ST_VSQ;
                end
            end
            ST_CINIT:
            begin
                if (finish)
                begin
                    state_next = ST_CRUN;
                end
            end
            ST_CRUN:
            begin
                if (finish && n_reg == last_idx)
                begin
                    state_next = ST_AINIT;
                end
            end
            ST_AINIT:
            begin
                if (finish)
                begin
                    state_next = ST_ARUN;
                end
            end
            ST_ARUN:
            begin
                if (finish && n_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_VSQ:   state_next = mode ? ST_MG1 : ST_IDLE;
            ST_MG1:   state_next = ST_MG2;
            ST_MG2:   state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (iter_reg == 5'(SQRT_STEPS))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (load_acc && !len_eff[LEN_W-1])
        begin
            samp_mem[len_eff[ADDR_W-1:0]] <= sample;
        end
        samp_q_reg <= samp_mem[n_reg];
    end

    always_ff @(posedge clk)
    begin
        if (finish && state_reg == ST_CRUN)
        begin
            line_mem[n_reg] <= sat_val;
        end
        else if (finish && state_reg == ST_ARUN)
        begin
            line_mem[n_reg] <= {{(VAL_W-SAMPLE_W){1'b0}}, clamp_byte};
        end
        line_q_reg <= line_mem[line_addr];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            fwd_num_01_reg    <= '0;
            fwd_num_23_reg    <= '0;
            den_12_reg        <= '0;
            den_34_reg        <= '0;
            bwd_num_12_reg    <= '0;
            bwd_num_34_reg    <= '0;
            edge_gains_reg    <= '0;
            pass_control_reg  <= PC_RESET;
            line_length_reg   <= '0;
            drain_pos_reg     <= '0;
            line_ready_reg    <= 1'b0;
            n_reg             <= '0;
            step_reg          <= '0;
            mul_v_reg         <= 1'b0;
            term_v_reg        <= 1'b0;
            iter_reg          <= '0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            result_strobe_reg <= emit;
            mul_v_reg         <= issue;
            term_v_reg        <= mul_v_reg && mul_h_reg;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FWD_NUM_01:   fwd_num_01_reg   <= cfg_data;
                    REG_FWD_NUM_23:   fwd_num_23_reg   <= cfg_data;
                    REG_DEN_12:       den_12_reg       <= cfg_data;
                    REG_DEN_34:       den_34_reg       <= cfg_data;
                    REG_BWD_NUM_12:   bwd_num_12_reg   <= cfg_data;
                    REG_BWD_NUM_34:   bwd_num_34_reg   <= cfg_data;
                    REG_EDGE_GAINS:   edge_gains_reg   <= cfg_data;
                    REG_PASS_CONTROL: pass_control_reg <= cfg_data[PC_W-1:0];
                    default:          pass_control_reg <= pass_control_reg;
                endcase
            end

            if (load_acc)
            begin
                line_ready_reg  <= 1'b0;
                drain_pos_reg   <= '0;
                line_length_reg <= len_eff[LEN_W-1] ? len_eff : LEN_W'(len_eff + 1'b1);
                n_reg           <= '0;
                step_reg        <= '0;
            end

            if (in_walk)
            begin
                step_reg <= finish ? '0 : 5'(step_reg + 5'd1);
            end

            if (finish)
            begin
                if (state_reg == ST_CRUN)
                begin
                    if (n_reg != last_idx)
                    begin
                        n_reg <= ADDR_W'(n_reg + 1'b1);
                    end
                end
                else if (state_reg == ST_ARUN)
                begin
                    if (n_reg == '0)
                    begin
                        line_ready_reg <= 1'b1;
                        drain_pos_reg  <= '0;
                    end
                    else
                    begin
                        n_reg <= ADDR_W'(n_reg - 1'b1);
                    end
                end
            end

            if (state_reg == ST_MG2)
            begin
                iter_reg <= '0;
            end
            else if (state_reg == ST_ROOT)
            begin
                iter_reg <= 5'(iter_reg + 5'd1);
            end

            if (emit)
            begin
                if (pos_inc >= line_length_reg)
                begin
                    line_ready_reg  <= 1'b0;
                    line_length_reg <= '0;
                    drain_pos_reg   <= '0;
                end
                else
                begin
                    drain_pos_reg <= pos_inc;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            mul_reg     <= op_half * coef_sel;
            mul_h_reg   <= issue_idx[0];
            mul_neg_reg <= t_sel[2] && !is_init;
        end
        if (mul_v_reg && !mul_h_reg)
        begin
            lo_reg <= mul_reg;
        end
        if (mul_v_reg && mul_h_reg)
        begin
            term_reg     <= full_sum[FULL_W-1:COEF_FRAC_BITS];
            term_neg_reg <= mul_neg_reg;
        end
        if (step_reg == '0)
        begin
            acc_reg <= '0;
        end
        else if (term_v_reg)
        begin
            if (term_neg_reg)
            begin
                acc_reg <= acc_reg - $signed({{(ACC_W-TERM_W){term_reg[TERM_W-1]}}, term_reg});
            end
            else
            begin
                acc_reg <= acc_reg + $signed({{(ACC_W-TERM_W){term_reg[TERM_W-1]}}, term_reg});
            end
        end

        if (finish)
        begin
            if (is_init)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    xh_reg[k] <= samp_q_reg;
                    yh_reg[k] <= acc_reg[VAL_W-1:0];
                end
            end
            else
            begin
                xh_reg[3] <= xh_reg[2];
                xh_reg[2] <= xh_reg[1];
                xh_reg[1] <= xh_reg[0];
                xh_reg[0] <= samp_q_reg;
                yh_reg[3] <= yh_reg[2];
                yh_reg[2] <= yh_reg[1];
                yh_reg[1] <= yh_reg[0];
                yh_reg[0] <= $signed(sat_val);
            end
        end

        if (drain_acc)
        begin
            h_reg <= other_pass;
        end

        unique case (state_reg)
            ST_VSQ:  prod_reg <= (RAD_W-1)'(sq_sum);
            ST_MG1:  prod_reg <= (RAD_W-1)'(prod_reg[16:0]) * (RAD_W-1)'(gain);
            ST_MG2:
            begin
                rad_reg  <= {1'b0, (RAD_W-1)'(prod_reg[32:0]) * (RAD_W-1)'(gain)};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_ROOT:
            begin
                if (iter_reg != 5'(SQRT_STEPS))
                begin
                    rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                    if (rem_shift >= trial)
                    begin
                        rem_reg  <= REM_W'(rem_shift - trial);
                        root_reg <= {root_reg[SQRT_STEPS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_shift[REM_W-1:0];
                        root_reg <= {root_reg[SQRT_STEPS-2:0], 1'b0};
                    end
                end
            end
            default:  prod_reg <= prod_reg;
        endcase

        if (emit)
        begin
            result_value_reg <= emit_value;
            result_last_reg  <= (pos_inc == line_length_reg);
        end
    end

endmodule
